// ===== hdl/generational_handle_slot_table_assert.svh =====
// Assertion macros shared by the slot table RTL.
`ifndef GENERATIONAL_HANDLE_SLOT_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_SLOT_TABLE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GHST_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("slot table check failed");

// Check a property on every clock edge, reset included.
`define GHST_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("slot table check failed");

`endif

// ===== hdl/ghst_pkg.sv =====
// Shared constants and codes of the generational slot table.
package ghst_pkg;
	localparam int MAX_ENTRIES = 1024;
	localparam int AW = 10;
	localparam int CW = 11;
	localparam int GW = 16;
	localparam int RW = 64;
	localparam logic [GW-1:0] GEN_MAX = 16'hFFFF;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_ADD_SH = 2'd1;
	localparam logic [1:0] ACT_FREE   = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] count_t;
	typedef logic [GW-1:0] gen_t;
	typedef logic [RW-1:0] rec_t;
endpackage

// ===== hdl/generational_handle_slot_table.sv =====
// Top level of the generational slot table: sequencer and table memories.
//
// Channel   Handshake              Fields
// request   start, busy            action, light_record, handle_slot,
//                                  handle_generation, dense_position
// result    done (one-cycle pulse) status, out_slot, out_generation, out_record,
//                                  out_shadowing, total_count, shadowing_count
//
// Add ends early when the table is full, Read when out of range, and
// Free when stale. An accepted free makes up to two swaps of dense
// positions, each reading both and then writing both over the single ports.
// Reset clears only control state; never-allocated slots are tracked by a
// high-water mark, so no clearing pass is needed.
// The result is shown for one cycle on done; the receiver cannot stall.
`include "generational_handle_slot_table_assert.svh"

module generational_handle_slot_table
	import ghst_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    action,
	input  logic [RW-1:0] light_record,
	input  logic [AW-1:0] handle_slot,
	input  logic [GW-1:0] handle_generation,
	input  logic [AW-1:0] dense_position,
	output logic          done,
	output logic [1:0]    status,
	output logic [AW-1:0] out_slot,
	output logic [GW-1:0] out_generation,
	output logic [RW-1:0] out_record,
	output logic          out_shadowing,
	output logic [CW-1:0] total_count,
	output logic [CW-1:0] shadowing_count
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_A1    = 4'd1;
	localparam logic [3:0] S_A2    = 4'd2;
	localparam logic [3:0] S_A3    = 4'd3;
	localparam logic [3:0] S_F1    = 4'd4;
	localparam logic [3:0] S_F2    = 4'd5;
	localparam logic [3:0] S_F3    = 4'd6;
	localparam logic [3:0] S_SWCHK = 4'd7;
	localparam logic [3:0] S_SWRA  = 4'd8;
	localparam logic [3:0] S_SWRB  = 4'd9;
	localparam logic [3:0] S_SWWA  = 4'd10;
	localparam logic [3:0] S_SWWB  = 4'd11;
	localparam logic [3:0] S_FE    = 4'd12;
	localparam logic [3:0] S_R1    = 4'd13;
	localparam logic [3:0] S_R2    = 4'd14;
	localparam logic [3:0] S_R3    = 4'd15;

	localparam count_t MAX_C = count_t'(MAX_ENTRIES);

	// Table memories
	count_t slot_map [MAX_ENTRIES];
	addr_t  dense_owner [MAX_ENTRIES];
	gen_t   slot_generation [MAX_ENTRIES];
	rec_t   records [MAX_ENTRIES];

	logic [3:0] state_q;
	count_t     fh_q, lc_q, sc_q, hw_q;
	logic [1:0] act_q;
	rec_t       rec_in_q;
	addr_t      hslot_q, pos_q;
	gen_t       hgen_q;
	count_t     link_q, d_q;
	gen_t       gen_q;
	logic       ok_q, shfree_q, second_q;
	addr_t      sw_a_q, sw_b_q, oa_q, owner_q;
	rec_t       ra_q;

	logic       done_q, osh_q;
	logic [1:0] status_q;
	addr_t      oslot_q;
	gen_t       ogen_q;
	rec_t       orec_q;

	logic   sm_we, dow_we, gen_we, rec_we;
	addr_t  sm_wa, sm_ra, dow_wa, dow_ra, gen_wa, gen_ra, rec_wa, rec_ra;
	count_t sm_wd, sm_rd;
	addr_t  dow_wd, dow_rd;
	gen_t   gen_wd, gen_rd;
	rec_t   rec_wd, rec_rd;

	logic   fresh_fh, fresh_hs, shadow_move;
	count_t fh_link;
	gen_t   fh_gen, hs_gen;
	count_t hs_d;
	addr_t  dpos;

	assign fresh_fh    = fh_q >= hw_q;
	assign fh_link     = fresh_fh ? fh_q + 11'd1 : sm_rd;
	assign fh_gen      = fresh_fh ? '0 : gen_rd;
	assign fresh_hs    = {1'b0, hslot_q} >= hw_q;
	assign hs_gen      = fresh_hs ? '0 : gen_rd;
	assign hs_d        = fresh_hs ? {1'b0, hslot_q} + 11'd1 : sm_rd;
	assign shadow_move = (act_q == ACT_ADD_SH) && (sc_q != lc_q);
	assign dpos        = (act_q == ACT_ADD_SH) ? sc_q[AW-1:0] : lc_q[AW-1:0];

	// Drive memory ports from the sequencer state
	always_comb begin
		sm_we = 1'b0; sm_wa = '0; sm_wd = '0; sm_ra = '0;
		dow_we = 1'b0; dow_wa = '0; dow_wd = '0; dow_ra = '0;
		gen_we = 1'b0; gen_wa = '0; gen_wd = '0; gen_ra = '0;
		rec_we = 1'b0; rec_wa = '0; rec_wd = '0; rec_ra = '0;
		unique case (state_q)
			S_A1: begin
				sm_ra  = fh_q[AW-1:0];
				gen_ra = fh_q[AW-1:0];
				dow_ra = sc_q[AW-1:0];
				rec_ra = sc_q[AW-1:0];
			end
			S_A2: begin
				if (shadow_move) begin
					dow_we = 1'b1; dow_wa = lc_q[AW-1:0]; dow_wd = dow_rd;
					rec_we = 1'b1; rec_wa = lc_q[AW-1:0]; rec_wd = rec_rd;
					sm_we  = 1'b1; sm_wa = dow_rd; sm_wd = lc_q;
				end
			end
			S_A3: begin
				sm_we  = 1'b1; sm_wa = fh_q[AW-1:0]; sm_wd = {1'b0, dpos};
				dow_we = 1'b1; dow_wa = dpos; dow_wd = fh_q[AW-1:0];
				rec_we = 1'b1; rec_wa = dpos; rec_wd = rec_in_q;
				// zero the generation of a slot taken for the first time
				gen_we = fresh_fh; gen_wa = fh_q[AW-1:0]; gen_wd = '0;
			end
			S_F1: begin
				sm_ra  = hslot_q;
				gen_ra = hslot_q;
			end
			S_F2: begin
				dow_ra = hs_d[AW-1:0];
			end
			S_F3: begin
				gen_wa = hslot_q;
				gen_wd = gen_q + 16'd1;
				gen_we = ok_q && (d_q < lc_q) && (dow_rd == hslot_q);
			end
			S_SWRA: begin
				dow_ra = sw_a_q; rec_ra = sw_a_q;
			end
			S_SWRB: begin
				dow_ra = sw_b_q; rec_ra = sw_b_q;
			end
			S_SWWA: begin
				dow_we = 1'b1; dow_wa = sw_a_q; dow_wd = dow_rd;
				rec_we = 1'b1; rec_wa = sw_a_q; rec_wd = rec_rd;
				sm_we  = 1'b1; sm_wa = dow_rd; sm_wd = {1'b0, sw_a_q};
			end
			S_SWWB: begin
				dow_we = 1'b1; dow_wa = sw_b_q; dow_wd = oa_q;
				rec_we = 1'b1; rec_wa = sw_b_q; rec_wd = ra_q;
				sm_we  = 1'b1; sm_wa = oa_q; sm_wd = {1'b0, sw_b_q};
			end
			S_FE: begin
				sm_we = gen_q != GEN_MAX; sm_wa = hslot_q; sm_wd = fh_q;
			end
			S_R1: begin
				dow_ra = pos_q; rec_ra = pos_q;
			end
			S_R2: begin
				gen_ra = dow_rd;
			end
			default: begin
			end
		endcase
	end

	// Table memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (sm_we) slot_map[sm_wa] <= sm_wd;
		if (dow_we) dense_owner[dow_wa] <= dow_wd;
		if (gen_we) slot_generation[gen_wa] <= gen_wd;
		if (rec_we) records[rec_wa] <= rec_wd;
		sm_rd  <= slot_map[sm_ra];
		dow_rd <= dense_owner[dow_ra];
		gen_rd <= slot_generation[gen_ra];
		rec_rd <= records[rec_ra];
	end

	// Sequencer and table counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fh_q     <= '0;
			lc_q     <= '0;
			sc_q     <= '0;
			hw_q     <= '0;
			done_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q    <= action;
						rec_in_q <= light_record;
						hslot_q  <= handle_slot;
						hgen_q   <= handle_generation;
						pos_q    <= dense_position;
						unique case (action)
							ACT_ADD, ACT_ADD_SH: state_q <= S_A1;
							ACT_FREE:            state_q <= S_F1;
							default:             state_q <= S_R1;
						endcase
					end
				end
				S_A1: begin
					if (lc_q >= MAX_C || fh_q >= MAX_C) begin
						status_q <= ST_FULL; oslot_q <= '0; ogen_q <= '0;
						orec_q <= '0; osh_q <= 1'b0; done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_A2;
					end
				end
				S_A2: begin
					link_q  <= fh_link;
					gen_q   <= fh_gen;
					state_q <= S_A3;
				end
				S_A3: begin
					if (fresh_fh) hw_q <= fh_q + 11'd1;
					fh_q <= link_q;
					lc_q <= lc_q + 11'd1;
					if (act_q == ACT_ADD_SH) sc_q <= sc_q + 11'd1;
					status_q <= ST_OK; oslot_q <= fh_q[AW-1:0]; ogen_q <= gen_q;
					orec_q <= '0; osh_q <= act_q == ACT_ADD_SH; done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F1: begin
					state_q <= S_F2;
				end
				S_F2: begin
					gen_q   <= hs_gen;
					d_q     <= hs_d;
					ok_q    <= hs_gen == hgen_q;
					state_q <= S_F3;
				end
				S_F3: begin
					if (!(ok_q && (d_q < lc_q) && (dow_rd == hslot_q))) begin
						status_q <= ST_STALE; oslot_q <= '0; ogen_q <= '0;
						orec_q <= '0; osh_q <= 1'b0; done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						gen_q  <= gen_q + 16'd1;
						sw_a_q <= d_q[AW-1:0];
						if (d_q < sc_q) begin
							shfree_q <= 1'b1; second_q <= 1'b1;
							sw_b_q   <= sc_q[AW-1:0] - 10'd1;
						end else begin
							shfree_q <= 1'b0; second_q <= 1'b0;
							sw_b_q   <= lc_q[AW-1:0] - 10'd1;
						end
						state_q <= S_SWCHK;
					end
				end
				S_SWCHK: begin
					if (sw_a_q != sw_b_q) begin
						state_q <= S_SWRA;
					end else if (second_q) begin
						second_q <= 1'b0;
						sw_a_q   <= sc_q[AW-1:0] - 10'd1;
						sw_b_q   <= lc_q[AW-1:0] - 10'd1;
					end else begin
						state_q <= S_FE;
					end
				end
				S_SWRA: begin
					state_q <= S_SWRB;
				end
				S_SWRB: begin
					oa_q    <= dow_rd;
					ra_q    <= rec_rd;
					state_q <= S_SWWA;
				end
				S_SWWA: begin
					state_q <= S_SWWB;
				end
				S_SWWB: begin
					if (second_q) begin
						second_q <= 1'b0;
						sw_a_q   <= sc_q[AW-1:0] - 10'd1;
						sw_b_q   <= lc_q[AW-1:0] - 10'd1;
						state_q  <= S_SWCHK;
					end else begin
						state_q <= S_FE;
					end
				end
				S_FE: begin
					lc_q <= lc_q - 11'd1;
					if (shfree_q) sc_q <= sc_q - 11'd1;
					if (gen_q != GEN_MAX) fh_q <= {1'b0, hslot_q};
					status_q <= ST_OK; oslot_q <= '0; ogen_q <= '0;
					orec_q <= '0; osh_q <= 1'b0; done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_R1: begin
					if ({1'b0, pos_q} >= lc_q) begin
						status_q <= ST_RANGE; oslot_q <= '0; ogen_q <= '0;
						orec_q <= '0; osh_q <= 1'b0; done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_R2;
					end
				end
				S_R2: begin
					owner_q <= dow_rd;
					ra_q    <= rec_rd;
					state_q <= S_R3;
				end
				S_R3: begin
					status_q <= ST_OK; oslot_q <= owner_q; ogen_q <= gen_rd;
					orec_q <= ra_q; osh_q <= {1'b0, pos_q} < sc_q; done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = state_q != S_IDLE;
	assign done            = done_q;
	assign status          = status_q;
	assign out_slot        = oslot_q;
	assign out_generation  = ogen_q;
	assign out_record      = orec_q;
	assign out_shadowing   = osh_q;
	assign total_count     = lc_q;
	assign shadowing_count = sc_q;

	`GHST_ASSERT_ALWAYS(a_part_packed, sc_q <= lc_q)
	`GHST_ASSERT(a_live_bound, lc_q <= MAX_C)
	`GHST_ASSERT(a_head_below_mark, fh_q <= hw_q)
	`GHST_ASSERT(a_done_ends_work, done_q |-> state_q == S_IDLE)
	`GHST_ASSERT(a_take_sets_busy, (start && !busy) |=> busy)
endmodule
